/* hdl/tseq_pkg.sv */
// Shared types and constants of the timestamp sorted event queue.
package tseq_pkg;

	localparam int CHAN_W = 5;
	localparam int NOTE_W = 7;
	localparam int TIME_W = 53;
	localparam int HEAD_W = 54;

	localparam logic [HEAD_W-1:0] EMPTY_HEAD = 54'd9999999999999999;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [NOTE_W-1:0] note;
		logic [TIME_W-1:0] ts;
	} entry_t;

endpackage

/* hdl/tseq_if.sv */
// Handshake channels of the timestamp sorted event queue.
interface tseq_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [4:0]  channel;
	logic [6:0]  note;
	logic [52:0] event_time;

	modport source (output valid, input ready, output opcode, channel, note, event_time);
	modport sink (input valid, output ready, input opcode, channel, note, event_time);
endinterface

interface tseq_res_if #(parameter int CNT_W = 7);
	logic             valid;
	logic             ready;
	logic             popped_valid;
	logic [4:0]       popped_channel;
	logic [6:0]       popped_note;
	logic [52:0]      popped_time;
	logic [53:0]      head_time;
	logic [CNT_W-1:0] entry_count;
	logic [1:0]       error_code;

	modport source (output valid, input ready, output popped_valid, popped_channel,
		popped_note, popped_time, head_time, entry_count, error_code);
	modport sink (input valid, output ready, input popped_valid, popped_channel,
		popped_note, popped_time, head_time, entry_count, error_code);
endinterface

/* hdl/tseq_store.sv */
// Entry memory of the event queue: one write port and one registered read port.
module tseq_store
	import tseq_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/timestamp_sorted_event_queue_unit.sv */
// Pending note-off events kept in ascending timestamp order in a circular memory.
// A push into an empty or full queue goes straight to the finishing state; otherwise the
// insertion walk moves each stored entry with a later or equal time up one slot, tail first.
// A pop reads the head entry and, unless it was the last, the next one for the new head time;
// one request is in flight at a time; the result register lets the next request in while a result waits.
// Reset (arst_n low) empties the queue at once; the memory itself is not cleared.
module timestamp_sorted_event_queue_unit
	import tseq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tseq_req_if.sink    req,
	tseq_res_if.source  result
);

	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_INSERT,
		S_POP_HEAD,
		S_POP_NEXT,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [AW-1:0]     head_q;
	logic [HEAD_W-1:0] head_time_q;
	logic [AW-1:0]     k_q;
	entry_t            new_q;
	entry_t            pop_q;
	logic              pv_q;
	err_t              err_q;

	logic              res_valid_q;
	logic              res_pv_q;
	entry_t            res_pop_q;
	logic [HEAD_W-1:0] res_head_q;
	logic [CNT_W-1:0]  res_count_q;
	err_t              res_err_q;

	logic          accept;
	logic          is_pop;
	logic          is_full;
	logic          is_empty;
	logic          move_up;
	entry_t        req_entry;
	logic [CNT_W-1:0] cnt_m1;

	logic          wr_en;
	logic [AW-1:0] wr_off;
	logic [AW:0]   wr_sum;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_off;
	logic [AW:0]   rd_sum;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_pop    = (req.opcode == OP_POP);
	assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign req_entry = '{chan: req.channel, note: req.note, ts: req.event_time};

	// A stored entry with a time not below the new one moves up, so the new event
	// lands ahead of equal times.
	assign move_up = (rd_data.ts >= new_q.ts);

	always_comb begin
		wr_en   = 1'b0;
		wr_off  = '0;
		wr_data = new_q;
		rd_en   = 1'b0;
		rd_off  = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!is_pop) begin
						if (is_empty) begin
							wr_en   = 1'b1;
							wr_data = req_entry;
						end else if (!is_full) begin
							rd_en  = 1'b1;
							rd_off = cnt_m1[AW-1:0];
						end
					end else if (!is_empty) begin
						rd_en = 1'b1;
					end
				end
			end
			S_SCAN: begin
				wr_en  = 1'b1;
				wr_off = k_q + AW'(1);
				if (move_up) begin
					wr_data = rd_data;
					if (k_q != '0) begin
						rd_en  = 1'b1;
						rd_off = k_q - AW'(1);
					end
				end
			end
			S_INSERT: begin
				wr_en = 1'b1;
			end
			S_POP_HEAD: begin
				if (count_q != CNT_W'(1)) begin
					rd_en  = 1'b1;
					rd_off = AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Logical offsets map onto the ring starting at the head slot.
	assign wr_sum  = {1'b0, head_q} + {1'b0, wr_off};
	assign wr_addr = (wr_sum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(wr_sum - (AW+1)'(QUEUE_DEPTH)) : wr_sum[AW-1:0];
	assign rd_sum  = {1'b0, head_q} + {1'b0, rd_off};
	assign rd_addr = (rd_sum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(rd_sum - (AW+1)'(QUEUE_DEPTH)) : rd_sum[AW-1:0];

	tseq_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			head_time_q <= EMPTY_HEAD;
			res_valid_q <= 1'b0;
		end else begin
			// In the finishing state the result register is reloaded below instead.
			if (res_valid_q && result.ready && (state_q != S_FINISH)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q <= req_entry;
						pv_q  <= 1'b0;
						pop_q <= '0;
						if (!is_pop) begin
							if (is_full) begin
								err_q   <= ERR_FULL;
								state_q <= S_FINISH;
							end else if (is_empty) begin
								err_q       <= ERR_OK;
								count_q     <= CNT_W'(1);
								head_time_q <= {1'b0, req.event_time};
								state_q     <= S_FINISH;
							end else begin
								err_q   <= ERR_OK;
								k_q     <= cnt_m1[AW-1:0];
								state_q <= S_SCAN;
							end
						end else if (is_empty) begin
							err_q   <= ERR_EMPTY;
							state_q <= S_FINISH;
						end else begin
							err_q   <= ERR_OK;
							state_q <= S_POP_HEAD;
						end
					end
				end
				S_SCAN: begin
					if (move_up) begin
						if (k_q == '0) begin
							state_q <= S_INSERT;
						end else begin
							k_q <= k_q - AW'(1);
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_FINISH;
					end
				end
				S_INSERT: begin
					count_q     <= count_q + CNT_W'(1);
					head_time_q <= {1'b0, new_q.ts};
					state_q     <= S_FINISH;
				end
				S_POP_HEAD: begin
					pop_q   <= rd_data;
					pv_q    <= 1'b1;
					count_q <= cnt_m1;
					head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
					if (count_q == CNT_W'(1)) begin
						head_time_q <= EMPTY_HEAD;
						state_q     <= S_FINISH;
					end else begin
						state_q <= S_POP_NEXT;
					end
				end
				S_POP_NEXT: begin
					head_time_q <= {1'b0, rd_data.ts};
					state_q     <= S_FINISH;
				end
				S_FINISH: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_pv_q    <= pv_q;
						res_pop_q   <= pop_q;
						res_head_q  <= head_time_q;
						res_count_q <= count_q;
						res_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = res_valid_q;
	assign result.popped_valid   = res_pv_q;
	assign result.popped_channel = res_pop_q.chan;
	assign result.popped_note    = res_pop_q.note;
	assign result.popped_time    = res_pop_q.ts;
	assign result.head_time      = res_head_q;
	assign result.entry_count    = res_count_q;
	assign result.error_code     = res_err_q;

endmodule

/* hdl/tseq_checker.sv */
// Port-level checks of the event queue and their binding to the top level.
module tseq_checker
	import tseq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int CNT_W       = 7
) (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic              popped_valid,
	input logic [TIME_W-1:0] popped_time,
	input logic [HEAD_W-1:0] head_time,
	input logic [CNT_W-1:0]  entry_count,
	input logic [1:0]        error_code
);

	// The head shows the empty mark exactly when nothing is stored.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((entry_count == '0) == (head_time == EMPTY_HEAD)))
		else $error("head time and entry count disagree on an empty queue");

	// A dropped push is only reported when the queue is full.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (error_code == ERR_FULL) |-> (entry_count == CNT_W'(QUEUE_DEPTH)))
		else $error("push dropped while the queue was not full");

	// A returned event never comes after what is left at the head.
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && popped_valid && (entry_count != '0) |->
			({1'b0, popped_time} <= head_time) && (error_code == ERR_OK))
		else $error("popped event is later than the new head");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(entry_count) && $stable(head_time))
		else $error("result dropped or changed while stalled");

endmodule

bind timestamp_sorted_event_queue_unit tseq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.CNT_W       (CNT_W)
) u_tseq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.popped_valid (result.popped_valid),
	.popped_time  (result.popped_time),
	.head_time    (result.head_time),
	.entry_count  (result.entry_count),
	.error_code   (result.error_code)
);
